// File: design/sql_token_scanner_defines.svh
// Assertion macros used by the checker file of the SQL token scanner.
`ifndef SQL_TOKEN_SCANNER_DEFINES_SVH
`define SQL_TOKEN_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SQLTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SQLTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sqlts_pkg.sv
// Shared widths, token kind codes and result types of the SQL token scanner.
package sqlts_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 24;
  localparam int unsigned OUT_W           = 24;
  localparam int unsigned KIND_W          = 5;
  localparam int unsigned MAX_RES         = 3;
  localparam int unsigned CNT_W           = 2;

  localparam logic [KIND_W-1:0] K_LPAREN = 5'd0;
  localparam logic [KIND_W-1:0] K_RPAREN = 5'd1;
  localparam logic [KIND_W-1:0] K_LBRACE = 5'd2;
  localparam logic [KIND_W-1:0] K_RBRACE = 5'd3;
  localparam logic [KIND_W-1:0] K_COMMA  = 5'd4;
  localparam logic [KIND_W-1:0] K_DOT    = 5'd5;
  localparam logic [KIND_W-1:0] K_MINUS  = 5'd6;
  localparam logic [KIND_W-1:0] K_PLUS   = 5'd7;
  localparam logic [KIND_W-1:0] K_SEMI   = 5'd8;
  localparam logic [KIND_W-1:0] K_SLASH  = 5'd9;
  localparam logic [KIND_W-1:0] K_STAR   = 5'd10;
  localparam logic [KIND_W-1:0] K_BANG   = 5'd11;
  localparam logic [KIND_W-1:0] K_EQ     = 5'd13;
  localparam logic [KIND_W-1:0] K_GT     = 5'd15;
  localparam logic [KIND_W-1:0] K_LT     = 5'd17;
  localparam logic [KIND_W-1:0] K_WORD   = 5'd19;
  localparam logic [KIND_W-1:0] K_NUMBER = 5'd20;
  localparam logic [KIND_W-1:0] K_STRING = 5'd21;
  localparam logic [KIND_W-1:0] K_BAD    = 5'd22;
  localparam logic [KIND_W-1:0] K_UNTERM = 5'd23;
  localparam logic [KIND_W-1:0] K_END    = 5'd24;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OUT_W-1:0]  start;
    logic [OUT_W-1:0]  stop;
    logic [OUT_W-1:0]  line;
    logic              last;
  } tok_t;

  // All results caused by one accepted byte, packed from entry 0 upwards.
  typedef struct packed {
    logic                     vld;
    logic [CNT_W-1:0]         num;
    tok_t [MAX_RES-1:0]       ent;
  } bundle_t;

endpackage

// File: design/sqlts_if.sv
// Handshake interfaces for the source byte and token channels.
interface sqlts_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       source_end;

  modport src (output valid, output source_byte, output source_end, input ready);
  modport snk (input valid, input source_byte, input source_end, output ready);
endinterface

interface sqlts_token_if;
  import sqlts_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] token_kind;
  logic [OUT_W-1:0]  start_offset;
  logic [OUT_W-1:0]  end_offset;
  logic [OUT_W-1:0]  line_number;
  logic              run_last;

  modport src (output valid, output token_kind, output start_offset, output end_offset,
               output line_number, output run_last, input ready);
  modport snk (input valid, input token_kind, input start_offset, input end_offset,
               input line_number, input run_last, output ready);
endinterface

// File: design/sql_token_scanner.sv
// A token appears on token_o the cycle after the byte that completes it is accepted.
// Throughput: one source byte per cycle while token_o is ready and each byte yields at most
// one token; a byte that yields k tokens (k up to 3) holds off the next byte until the single
// result register, which drains one token per transaction, has handed over all k.
// Reset (rst_ni low, asynchronous): scanner idle, offset 0, line 1, queued tokens dropped.
module sql_token_scanner #(
  parameter int unsigned OFFSET_BITS = sqlts_pkg::OFFSET_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sqlts_byte_if.snk     byte_i,
  sqlts_token_if.src    token_o
);
  import sqlts_pkg::*;

  bundle_t bundle;
  tok_t    tok;
  logic    load_ok;
  logic    accept;

  // Take a byte whenever the result register is empty or hands over its last token
  // in this cycle; a byte that yields nothing still advances the scan state.
  assign byte_i.ready = load_ok;
  assign accept       = byte_i.valid && load_ok;

  // Scan state plus the single-pass recognition of one byte.
  sqlts_scanner #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scanner (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (byte_i.source_byte),
    .end_i    (byte_i.source_end),
    .bundle_o (bundle)
  );

  // Hold the tokens of the last byte and drain them in order.
  sqlts_serializer u_serializer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .bundle_i  (bundle),
    .load_ok_o (load_ok),
    .valid_o   (token_o.valid),
    .ready_i   (token_o.ready),
    .tok_o     (tok)
  );

  assign token_o.token_kind   = tok.kind;
  assign token_o.start_offset = tok.start;
  assign token_o.end_offset   = tok.stop;
  assign token_o.line_number  = tok.line;
  assign token_o.run_last     = tok.last;

endmodule

// File: design/sqlts_scanner.sv
// Scan state and single-pass token recognition for one source byte.
module sqlts_scanner #(
  parameter int unsigned OFFSET_BITS = sqlts_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              end_i,
  output sqlts_pkg::bundle_t bundle_o
);
  import sqlts_pkg::*;

  typedef enum logic [11:0] {
    M_IDLE       = 12'b0000_0000_0001,
    M_WORD       = 12'b0000_0000_0010,
    M_NUM_INT    = 12'b0000_0000_0100,
    M_NUM_DOT    = 12'b0000_0000_1000,
    M_NUM_FRAC   = 12'b0000_0001_0000,
    M_OP         = 12'b0000_0010_0000,
    M_MINUS      = 12'b0000_0100_0000,
    M_SLASH      = 12'b0000_1000_0000,
    M_LINE_CMT   = 12'b0001_0000_0000,
    M_BLOCK_CMT  = 12'b0010_0000_0000,
    M_BLOCK_STAR = 12'b0100_0000_0000,
    M_STRING     = 12'b1000_0000_0000
  } scan_mode_e;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DQ    = 8'h22;

  localparam int unsigned NCAND = 4;

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_USCORE});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  // Single-byte tokens; hit flag in the top bit.
  function automatic logic [KIND_W:0] single_kind(input logic [7:0] c);
    logic [KIND_W:0] r;
    r = '0;
    case (c)
      8'h28:   r = {1'b1, K_LPAREN};
      8'h29:   r = {1'b1, K_RPAREN};
      8'h7B:   r = {1'b1, K_LBRACE};
      8'h7D:   r = {1'b1, K_RBRACE};
      8'h2C:   r = {1'b1, K_COMMA};
      CH_DOT:  r = {1'b1, K_DOT};
      8'h2B:   r = {1'b1, K_PLUS};
      8'h3B:   r = {1'b1, K_SEMI};
      CH_STAR: r = {1'b1, K_STAR};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
    logic [KIND_W-1:0] r;
    case (c)
      CH_BANG: r = K_BANG;
      CH_EQ:   r = K_EQ;
      CH_GT:   r = K_GT;
      CH_LT:   r = K_LT;
      default: r = K_BAD;
    endcase
    return r;
  endfunction

  scan_mode_e             mode_q, mode_d;
  logic [KIND_W-1:0]      pend_q, pend_d;
  logic [OFFSET_BITS-1:0] ts_q, ts_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [OFFSET_BITS-1:0] line_q, line_d;

  logic [NCAND-1:0]       cand_v;
  logic [KIND_W-1:0]      cand_k [NCAND];
  logic [OFFSET_BITS-1:0] cand_s [NCAND];
  logic [OFFSET_BITS-1:0] cand_e [NCAND];
  logic [OFFSET_BITS-1:0] cand_l [NCAND];

  logic [OFFSET_BITS-1:0] nxt;
  logic [OFFSET_BITS-1:0] line_new;
  logic [KIND_W:0]        sk;
  logic                   rescan;
  logic                   bump;
  scan_mode_e             mode_p1, mode_p2;
  logic [OFFSET_BITS-1:0] ts2;
  logic [KIND_W-1:0]      pend2;
  logic [CNT_W-1:0]       n;

  assign nxt = off_q + OFFSET_BITS'(1);
  assign sk  = single_kind(byte_i);

  always_comb begin
    cand_v  = '0;
    for (int i = 0; i < NCAND; i++) begin
      cand_k[i] = K_END;
      cand_s[i] = ts_q;
      cand_e[i] = off_q;
      cand_l[i] = line_q;
    end
    rescan  = 1'b0;
    bump    = 1'b0;
    mode_p1 = mode_q;

    // Continue or close the pending token.
    case (mode_q)
      M_WORD: begin
        if (!(is_letter(byte_i) || is_digit(byte_i))) begin
          cand_v[0] = 1'b1; cand_k[0] = K_WORD; rescan = 1'b1;
        end
      end
      M_NUM_INT: begin
        if (is_digit(byte_i)) begin
          mode_p1 = M_NUM_INT;
        end else if (byte_i == CH_DOT) begin
          mode_p1 = M_NUM_DOT;
        end else begin
          cand_v[0] = 1'b1; cand_k[0] = K_NUMBER; rescan = 1'b1;
        end
      end
      M_NUM_DOT, M_NUM_FRAC: begin
        if (is_digit(byte_i)) begin
          mode_p1 = M_NUM_FRAC;
        end else begin
          cand_v[0] = 1'b1; cand_k[0] = K_NUMBER; rescan = 1'b1;
        end
      end
      M_OP: begin
        cand_v[0] = 1'b1;
        if (byte_i == CH_EQ) begin
          cand_k[0] = pend_q + KIND_W'(1);
          cand_e[0] = nxt;
          mode_p1   = M_IDLE;
        end else begin
          cand_k[0] = pend_q;
          rescan    = 1'b1;
        end
      end
      M_MINUS: begin
        if (byte_i == CH_MINUS) begin
          mode_p1 = M_LINE_CMT;
        end else begin
          cand_v[0] = 1'b1; cand_k[0] = K_MINUS; rescan = 1'b1;
        end
      end
      M_SLASH: begin
        if (byte_i == CH_STAR) begin
          mode_p1 = M_BLOCK_CMT;
        end else begin
          cand_v[0] = 1'b1; cand_k[0] = K_SLASH; rescan = 1'b1;
        end
      end
      M_LINE_CMT: begin
        if (byte_i == CH_NL) begin
          bump = 1'b1; mode_p1 = M_IDLE;
        end
      end
      M_BLOCK_CMT: begin
        if (byte_i == CH_STAR) begin
          mode_p1 = M_BLOCK_STAR;
        end else if (byte_i == CH_NL) begin
          bump = 1'b1;
        end
      end
      M_BLOCK_STAR: begin
        if (byte_i == CH_SLASH) begin
          mode_p1 = M_IDLE;
        end else if (byte_i != CH_STAR) begin
          bump    = (byte_i == CH_NL);
          mode_p1 = M_BLOCK_CMT;
        end
      end
      M_STRING: begin
        if (byte_i == CH_QUOTE) begin
          cand_v[0] = 1'b1; cand_k[0] = K_STRING; cand_e[0] = nxt;
          mode_p1   = M_IDLE;
        end else if (byte_i == CH_NL) begin
          bump = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase

    // Scan the byte afresh from idle.
    mode_p2 = mode_p1;
    ts2     = ts_q;
    pend2   = pend_q;
    cand_s[1] = off_q;
    cand_e[1] = nxt;
    if (rescan) begin
      mode_p2 = M_IDLE;
      if (sk[KIND_W]) begin
        cand_v[1] = 1'b1; cand_k[1] = sk[KIND_W-1:0];
      end else begin
        ts2 = off_q;
        if (byte_i inside {CH_BANG, CH_EQ, CH_LT, CH_GT}) begin
          mode_p2 = M_OP; pend2 = op_kind(byte_i);
        end else if (byte_i == CH_MINUS) begin
          mode_p2 = M_MINUS;
        end else if (byte_i == CH_SLASH) begin
          mode_p2 = M_SLASH;
        end else if (byte_i == CH_QUOTE) begin
          mode_p2 = M_STRING;
        end else if (is_digit(byte_i)) begin
          mode_p2 = M_NUM_INT;
        end else if (is_letter(byte_i)) begin
          mode_p2 = M_WORD;
        end else if (byte_i == CH_NL) begin
          bump = 1'b1;
        end else if (!(byte_i inside {CH_SP, CH_CR, CH_TAB, CH_DQ})) begin
          cand_v[1] = 1'b1; cand_k[1] = K_BAD;
        end
      end
    end

    // Saturate the line count.
    line_new = (bump && (line_q != '1)) ? line_q + OFFSET_BITS'(1) : line_q;

    // Flush at end of source, then the end token.
    cand_s[2] = ts2;
    cand_e[2] = nxt;
    cand_l[2] = line_new;
    cand_s[3] = nxt;
    cand_e[3] = nxt;
    cand_l[3] = line_new;
    if (end_i) begin
      cand_v[3] = 1'b1;
      cand_v[2] = 1'b1;
      case (mode_p2)
        M_WORD:                           cand_k[2] = K_WORD;
        M_NUM_INT, M_NUM_DOT, M_NUM_FRAC: cand_k[2] = K_NUMBER;
        M_OP:                             cand_k[2] = pend2;
        M_MINUS:                          cand_k[2] = K_MINUS;
        M_SLASH:                          cand_k[2] = K_SLASH;
        M_STRING:                         cand_k[2] = K_UNTERM;
        M_BLOCK_CMT, M_BLOCK_STAR:        cand_k[2] = K_BAD;
        default:                          cand_v[2] = 1'b0;
      endcase
      mode_d = M_IDLE;
      pend_d = '0;
      ts_d   = '0;
      off_d  = '0;
      line_d = OFFSET_BITS'(1);
    end else begin
      mode_d = mode_p2;
      pend_d = pend2;
      ts_d   = ts2;
      off_d  = nxt;
      line_d = line_new;
    end
  end

  // Pack the candidates in order into the result bundle.
  always_comb begin
    bundle_o = '0;
    n        = '0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_v[i] && (n < CNT_W'(MAX_RES))) begin
        bundle_o.ent[n].kind  = cand_k[i];
        bundle_o.ent[n].start = OUT_W'(cand_s[i]);
        bundle_o.ent[n].stop  = OUT_W'(cand_e[i]);
        bundle_o.ent[n].line  = OUT_W'(cand_l[i]);
        n = n + CNT_W'(1);
      end
    end
    if (n != '0) begin
      bundle_o.ent[n - CNT_W'(1)].last = 1'b1;
    end
    bundle_o.num = n;
    bundle_o.vld = accept_i && (n != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      pend_q <= '0;
      ts_q   <= '0;
      off_q  <= '0;
      line_q <= OFFSET_BITS'(1);
    end else if (accept_i) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
      ts_q   <= ts_d;
      off_q  <= off_d;
      line_q <= line_d;
    end
  end

endmodule

// File: design/sqlts_serializer.sv
// Result register that hands out the tokens of one byte one transaction at a time.
module sqlts_serializer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sqlts_pkg::bundle_t bundle_i,
  output logic               load_ok_o,
  output logic               valid_o,
  input  logic               ready_i,
  output sqlts_pkg::tok_t    tok_o
);
  import sqlts_pkg::*;

  tok_t [MAX_RES-1:0] ent_q;
  logic [CNT_W-1:0]   num_q;
  logic [CNT_W-1:0]   idx_q;
  logic               take;
  logic               final_take;

  assign valid_o    = (num_q != '0);
  assign tok_o      = ent_q[idx_q];
  assign take       = valid_o && ready_i;
  assign final_take = take && (idx_q == num_q - CNT_W'(1));
  assign load_ok_o  = !valid_o || final_take;

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (bundle_i.vld) begin
      ent_q <= bundle_i.ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
      idx_q <= '0;
    end else if (bundle_i.vld) begin
      num_q <= bundle_i.num;
      idx_q <= '0;
    end else if (final_take) begin
      num_q <= '0;
      idx_q <= '0;
    end else if (take) begin
      idx_q <= idx_q + CNT_W'(1);
    end
  end

endmodule

// File: design/sqlts_checker.sv
// Port-level checks of the SQL token scanner and their bind to the top level.
`include "sql_token_scanner_defines.svh"

module sqlts_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [sqlts_pkg::KIND_W-1:0] token_kind_i,
  input logic [sqlts_pkg::OUT_W-1:0]  start_offset_i,
  input logic [sqlts_pkg::OUT_W-1:0]  end_offset_i,
  input logic                         run_last_i
);
  import sqlts_pkg::*;

  // The end token closes the byte's run and is empty.
  `SQLTS_ASSERT_NOW(a_end_token, out_valid_i && (token_kind_i == K_END), run_last_i && (start_offset_i == end_offset_i), "end token not last or not empty")

  // The rest of a byte's run follows without a gap.
  `SQLTS_ASSERT_NEXT(a_run_continues, out_valid_i && out_ready_i && !run_last_i, out_valid_i, "token run broken")

  // With no token waiting the scanner must take a byte.
  `SQLTS_ASSERT_NOW(a_ready_when_empty, !out_valid_i, in_ready_i, "stalled with empty result register")

  // A stalled token holds.
  `SQLTS_ASSERT_NEXT(a_hold_stalled, out_valid_i && !out_ready_i, out_valid_i && $stable(token_kind_i) && $stable(start_offset_i), "stalled token changed")

endmodule

bind sql_token_scanner sqlts_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (byte_i.ready),
  .out_valid_i    (token_o.valid),
  .out_ready_i    (token_o.ready),
  .token_kind_i   (token_o.token_kind),
  .start_offset_i (token_o.start_offset),
  .end_offset_i   (token_o.end_offset),
  .run_last_i     (token_o.run_last)
);
